>>> rtl/core/rmvd_pkg.sv
// ============================================================================
// rmvd_pkg: shared definitions for the RSSI moving variance detector
// Field widths, register codes, reset values, result codes and the command
// and status bundles that pass between the controller and the datapath.
// ============================================================================
package rmvd_pkg;

  localparam int RSSI_W     = 8;
  localparam int LEVEL_W    = 24;
  localparam int WIN_W      = 9;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int RING_DEPTH_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  localparam logic [WIN_W-1:0]         SAMPLE_WIN_RST = 9'd256;
  localparam logic [WIN_W-1:0]         AVG_WIN_RST    = 9'd64;
  localparam logic [WIN_W-1:0]         INTEG_WIN_RST  = 9'd3;
  localparam logic [THR_W-1:0]         THRESHOLD_RST  = 16'd3;
  localparam logic signed [RSSI_W-1:0] MIN_RSSI_RST   = -8'sd100;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_BOOT  = 2'd1,
    STAT_LOW   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_WIN = 3'd0,
    CFG_AVG_WIN    = 3'd1,
    CFG_INTEG_WIN  = 3'd2,
    CFG_THRESHOLD  = 3'd3,
    CFG_AR_EN      = 3'd4,
    CFG_ALARM_EN   = 3'd5,
    CFG_MIN_RSSI   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    sample_store;
    logic    loop_start;
    logic    loop_step;
    logic    loop_sel;
    logic    div_start;
    logic    dev_calc;
    logic    square;
    logic    dev_store;
    logic    filter;
    logic    res_load;
    status_t res_code;
  } rmvd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic too_low;
    logic filled;
    logic loop_done;
    logic div_busy;
    logic out_full;
  } rmvd_stat_t;

endpackage

>>> rtl/core/rmvd_if.sv
// ============================================================================
// rmvd_if: ready/valid channels of the RSSI moving variance detector
// The sample channel carries one signed RSSI value; the result channel
// carries a status code and a detection level.
// ============================================================================
interface rmvd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmvd_pkg::RSSI_W-1:0]   rssi;

  modport source (output valid, output rssi, input ready);
  modport sink   (input valid, input rssi, output ready);
endinterface

interface rmvd_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [rmvd_pkg::LEVEL_W-1:0]   level;

  modport source (output valid, output status, output level, input ready);
  modport sink   (input valid, input status, input level, output ready);
endinterface

>>> rtl/core/rmvd_ram.sv
// ============================================================================
// rmvd_ram: generic single write, single read RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module rmvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rmvd_div.sv
// ============================================================================
// rmvd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module rmvd_div #(
  parameter int N = 17,
  parameter int D = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  q;
  logic [D-1:0]  r;
  logic [D-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [D:0]    trial;
  logic [D:0]    diff;
  logic          ge;

  assign trial    = {r, q[N-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      q    <= dividend;
      r    <= '0;
      dvs  <= divisor;
      cnt  <= CW'(N);
      busy <= 1'b1;
    end else if (busy) begin
      // The remainder stays below the divisor, so D bits hold it.
      q   <= {q[N-2:0], ge};
      r   <= ge ? diff[D-1:0] : trial[D-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/rmvd_datapath.sv
// ============================================================================
// rmvd_datapath: registers, rings and arithmetic of the detector
// Holds the configuration registers, both rings, the ring walk, the mean
// divider, the squared deviation, the windowed sum, the filter and the
// result register. Save for config writes and out_ready, every action is started by a controller command.
// ============================================================================
module rmvd_datapath #(
  parameter int RING_DEPTH  = rmvd_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = rmvd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rmvd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [rmvd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [rmvd_pkg::RSSI_W-1:0]    rssi,
  input  rmvd_pkg::rmvd_cmd_t                   cmd,
  output rmvd_pkg::rmvd_stat_t                  stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rmvd_pkg::status_t                     out_status,
  output logic [rmvd_pkg::LEVEL_W-1:0]          out_level
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > rmvd_pkg::WIN_W) ? CNT_W : rmvd_pkg::WIN_W;
  localparam int ACC_W  = SAMPLE_BITS + PTR_W + 1;
  localparam int MEAN_W = SAMPLE_BITS + 1;
  localparam int DIF_W  = ((rmvd_pkg::RSSI_W > MEAN_W) ? rmvd_pkg::RSSI_W : MEAN_W) + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int SQX_W  = (SQ_W > rmvd_pkg::LEVEL_W) ? SQ_W : rmvd_pkg::LEVEL_W;
  localparam int LW     = rmvd_pkg::LEVEL_W;

  // Configuration registers.
  logic [rmvd_pkg::WIN_W-1:0]         sample_win;
  logic [rmvd_pkg::WIN_W-1:0]         avg_win;
  logic [rmvd_pkg::WIN_W-1:0]         integ_win;
  logic [rmvd_pkg::THR_W-1:0]         threshold;
  logic                               ar_en;
  logic                               alarm_en;
  logic signed [rmvd_pkg::RSSI_W-1:0] min_rssi;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_win <= rmvd_pkg::SAMPLE_WIN_RST;
      avg_win    <= rmvd_pkg::AVG_WIN_RST;
      integ_win  <= rmvd_pkg::INTEG_WIN_RST;
      threshold  <= rmvd_pkg::THRESHOLD_RST;
      ar_en      <= 1'b0;
      alarm_en   <= 1'b0;
      min_rssi   <= rmvd_pkg::MIN_RSSI_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        rmvd_pkg::CFG_SAMPLE_WIN: sample_win <= cfg_data[rmvd_pkg::WIN_W-1:0];
        rmvd_pkg::CFG_AVG_WIN:    avg_win    <= cfg_data[rmvd_pkg::WIN_W-1:0];
        rmvd_pkg::CFG_INTEG_WIN:  integ_win  <= cfg_data[rmvd_pkg::WIN_W-1:0];
        rmvd_pkg::CFG_THRESHOLD:  threshold  <= cfg_data[rmvd_pkg::THR_W-1:0];
        rmvd_pkg::CFG_AR_EN:      ar_en      <= cfg_data[0];
        rmvd_pkg::CFG_ALARM_EN:   alarm_en   <= cfg_data[0];
        rmvd_pkg::CFG_MIN_RSSI:   min_rssi   <= cfg_data[rmvd_pkg::RSSI_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window sizes after clamping.
  logic [CMP_W-1:0] sw_c, aw_c, iw_c;
  logic [CNT_W-1:0] sw, aw, iw;

  always_comb begin
    sw_c = CMP_W'(sample_win);
    if (sw_c == '0) begin
      sw_c = CMP_W'(1);
    end else if (sw_c > CMP_W'(RING_DEPTH)) begin
      sw_c = CMP_W'(RING_DEPTH);
    end
    aw_c = CMP_W'(avg_win);
    if (aw_c == '0) begin
      aw_c = CMP_W'(1);
    end else if (aw_c > sw_c) begin
      aw_c = sw_c;
    end
    iw_c = CMP_W'(integ_win);
    if (iw_c > sw_c) begin
      iw_c = sw_c;
    end
  end

  assign sw = CNT_W'(sw_c);
  assign aw = CNT_W'(aw_c);
  assign iw = CNT_W'(iw_c);

  // Sample latch and ring positions.
  logic signed [rmvd_pkg::RSSI_W-1:0] rssi_q;
  logic [PTR_W-1:0] sample_pos, dev_pos, newest, clr_idx;
  logic             filled;
  logic [PTR_W-1:0] spos_w, dpos_w;
  logic [CNT_W-1:0] spos_inc, dpos_inc;

  assign spos_w   = (CNT_W'(sample_pos) >= sw) ? '0 : sample_pos;
  assign dpos_w   = (CNT_W'(dev_pos) >= sw) ? '0 : dev_pos;
  assign spos_inc = CNT_W'(spos_w) + CNT_W'(1);
  assign dpos_inc = CNT_W'(dpos_w) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rssi_q <= rssi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_pos <= '0;
      dev_pos    <= '0;
      filled     <= 1'b0;
      clr_idx    <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.sample_store) begin
        newest <= spos_w;
        if (spos_inc >= sw) begin
          sample_pos <= '0;
          filled     <= 1'b1;
        end else begin
          sample_pos <= PTR_W'(spos_inc);
        end
      end
      if (cmd.dev_store) begin
        newest  <= dpos_w;
        dev_pos <= (dpos_inc >= sw) ? '0 : PTR_W'(dpos_inc);
      end
    end
  end

  // Rings.
  logic [SAMPLE_BITS-1:0] smp_rd;
  logic [LW-1:0]          dev_rd;
  logic [LW-1:0]          sq;
  logic [PTR_W-1:0]       rd_idx;
  logic [CNT_W-1:0]       rd_left;
  logic                   rd_pend;
  logic                   rd_issue;

  assign rd_issue = cmd.loop_step && (rd_left != '0);

  rmvd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (cmd.sample_store),
    .waddr (spos_w),
    .wdata (SAMPLE_BITS'(rssi_q)),
    .re    (rd_issue && !cmd.loop_sel),
    .raddr (rd_idx),
    .rdata (smp_rd)
  );

  rmvd_ram #(
    .WIDTH (LW),
    .DEPTH (RING_DEPTH)
  ) u_dev_ram (
    .clk   (clk),
    .we    (cmd.clear_step || cmd.dev_store),
    .waddr (cmd.clear_step ? clr_idx : dpos_w),
    .wdata (cmd.clear_step ? '0 : sq),
    .re    (rd_issue && cmd.loop_sel),
    .raddr (rd_idx),
    .rdata (dev_rd)
  );

  // Ring walk from the newest entry backward, one read a cycle.
  logic signed [ACC_W-1:0] acc;
  logic [LW-1:0]           sum;
  logic [LW:0]             sum_add;

  assign sum_add = {1'b0, sum} + {1'b0, dev_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_left <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.loop_start) begin
      rd_idx  <= newest;
      rd_left <= cmd.loop_sel ? iw : aw;
      rd_pend <= 1'b0;
      if (cmd.loop_sel) begin
        sum <= '0;
      end else begin
        acc <= '0;
      end
    end else if (cmd.loop_step) begin
      rd_pend <= rd_issue;
      if (rd_issue) begin
        rd_idx  <= (rd_idx == '0) ? PTR_W'(sw - CNT_W'(1)) : rd_idx - 1'b1;
        rd_left <= rd_left - 1'b1;
      end
      if (rd_pend) begin
        if (cmd.loop_sel) begin
          sum <= sum_add[LW] ? rmvd_pkg::LEVEL_MAX : sum_add[LW-1:0];
        end else begin
          acc <= acc + ACC_W'(signed'(smp_rd));
        end
      end
    end
  end

  // Mean: magnitude divided by the window, sign restored (truncates to zero).
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         quo;
  logic                     div_busy;
  logic signed [MEAN_W-1:0] mean;
  logic signed [DIF_W-1:0]  dif;
  logic [DIF_W-1:0]         dmag;
  logic [SQX_W-1:0]         sq_full;

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  rmvd_div #(
    .N (ACC_W),
    .D (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc_mag),
    .divisor  (aw),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign mean    = acc[ACC_W-1] ? -$signed(MEAN_W'(quo)) : $signed(MEAN_W'(quo));
  assign dif     = DIF_W'(rssi_q) - DIF_W'(mean);
  assign sq_full = SQX_W'(dmag) * SQX_W'(dmag);

  always_ff @(posedge clk) begin
    if (cmd.dev_calc) begin
      dmag <= dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
    end
    if (cmd.square) begin
      sq <= (sq_full > SQX_W'(rmvd_pkg::LEVEL_MAX)) ? rmvd_pkg::LEVEL_MAX : LW'(sq_full);
    end
  end

  // Smoothing filter and result register.
  logic [LW-1:0] smoothed;
  logic [LW:0]   filt_add;
  logic [LW-1:0] lvl_sel;
  logic [LW-1:0] lvl_gated;

  assign filt_add  = {1'b0, sum} + {1'b0, smoothed};
  assign lvl_sel   = ar_en ? smoothed : sum;
  assign lvl_gated = (alarm_en && (lvl_sel < LW'(threshold))) ? '0 : lvl_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
    end else if (cmd.filter) begin
      smoothed <= filt_add[LW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= cmd.res_code;
      out_level  <= (cmd.res_code == rmvd_pkg::STAT_VALID) ? lvl_gated : '0;
    end
  end

  assign stat.clear_last = (clr_idx == PTR_W'(RING_DEPTH - 1));
  assign stat.too_low    = (rssi_q < min_rssi);
  assign stat.filled     = filled;
  assign stat.loop_done  = (rd_left == '0) && !rd_pend;
  assign stat.div_busy   = div_busy;
  assign stat.out_full   = out_valid && !out_ready;

endmodule

>>> rtl/core/rmvd_ctrl.sv
// ============================================================================
// rmvd_ctrl: sequencing state machine of the detector
// Runs the clearing pass after reset, then walks each sample through check,
// store, mean, divide, square, sum and filter; low or booting ones end early.
// ============================================================================
module rmvd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rmvd_pkg::rmvd_stat_t stat,
  output rmvd_pkg::rmvd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_STORE,
    S_FILL,
    S_MEAN_GO,
    S_MEAN,
    S_DIV_GO,
    S_DIV,
    S_DEV,
    S_SQUARE,
    S_DEV_STORE,
    S_SUM_GO,
    S_SUM,
    S_FILTER,
    S_DONE
  } state_t;

  state_t            state;
  rmvd_pkg::status_t res_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= rmvd_pkg::STAT_VALID;
    end else begin
      case (state)
        S_CLEAR:     if (stat.clear_last) state <= S_IDLE;
        S_IDLE:      if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (stat.too_low) begin
            res_code <= rmvd_pkg::STAT_LOW;
            state    <= S_DONE;
          end else begin
            state <= S_STORE;
          end
        end
        S_STORE:     state <= S_FILL;
        S_FILL: begin
          if (!stat.filled) begin
            res_code <= rmvd_pkg::STAT_BOOT;
            state    <= S_DONE;
          end else begin
            state <= S_MEAN_GO;
          end
        end
        S_MEAN_GO:   state <= S_MEAN;
        S_MEAN:      if (stat.loop_done) state <= S_DIV_GO;
        S_DIV_GO:    state <= S_DIV;
        S_DIV:       if (!stat.div_busy) state <= S_DEV;
        S_DEV:       state <= S_SQUARE;
        S_SQUARE:    state <= S_DEV_STORE;
        S_DEV_STORE: state <= S_SUM_GO;
        S_SUM_GO:    state <= S_SUM;
        S_SUM:       if (stat.loop_done) state <= S_FILTER;
        S_FILTER: begin
          res_code <= rmvd_pkg::STAT_VALID;
          state    <= S_DONE;
        end
        S_DONE:      if (!stat.out_full) state <= S_IDLE;
        default:     state <= S_CLEAR;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd              = '0;
    cmd.res_code     = res_code;
    cmd.clear_step   = (state == S_CLEAR);
    cmd.load         = (state == S_IDLE) && in_valid;
    cmd.sample_store = (state == S_STORE);
    cmd.loop_start   = (state == S_MEAN_GO) || (state == S_SUM_GO);
    cmd.loop_step    = (state == S_MEAN) || (state == S_SUM);
    cmd.loop_sel     = (state == S_SUM_GO) || (state == S_SUM);
    cmd.div_start    = (state == S_DIV_GO);
    cmd.dev_calc     = (state == S_DEV);
    cmd.square       = (state == S_SQUARE);
    cmd.dev_store    = (state == S_DEV_STORE);
    cmd.filter       = (state == S_FILTER);
    cmd.res_load     = (state == S_DONE) && !stat.out_full;
  end

endmodule

>>> rtl/core/rssi_moving_variance_detector.sv
// ============================================================================
// rssi_moving_variance_detector: motion detection from RSSI variance
// Top level: joins the sequencing controller to the datapath and exposes
// the sample channel, the result channel and the configuration port.
// ============================================================================
// Usage. Samples enter on in_ch, a ready/valid channel; a transaction takes
// place at a rising edge with valid and ready both high. Every sample gives
// exactly one transaction on out_ch: status 2 when the sample is below
// min_rssi, status 1 while the sample ring fills for the first time, and
// status 0 with the detection level afterwards. Registers are written
// through cfg_we, cfg_idx and cfg_data while no sample is in flight.
// Steps. A rejected sample ends after the check and a booting one after the
// store. A full sample also runs two ring walks, over avg_window and then
// integ_window entries, the mean divider and the deviation steps; the ring
// walks read one RAM entry per cycle and the mean divider retires one
// quotient bit per cycle. One sample is processed at a time.
// Reset. A synchronous reset loads the register defaults and then clears
// every entry of the deviation ring, one entry per cycle; in_ch stays not
// ready until that pass ends.
// Stalls. The result sits in an output register, so the block takes the
// next sample while out_ch is stalled, and waits only if a second result
// is ready before the first one has been taken.
// ============================================================================
module rssi_moving_variance_detector #(
  parameter int RING_DEPTH  = rmvd_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = rmvd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  rmvd_in_if.sink                           in_ch,
  rmvd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rmvd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [rmvd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rmvd_pkg::rmvd_cmd_t  cmd;
  rmvd_pkg::rmvd_stat_t stat;
  rmvd_pkg::status_t    res_status;

  // The controller owns sequencing and the result code; all other values live in the datapath.
  rmvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmvd_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .rssi       (in_ch.rssi),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (res_status),
    .out_level  (out_ch.level)
  );

  assign out_ch.status = res_status;

  // At most one datapath action is commanded in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.load, cmd.sample_store, cmd.loop_start, cmd.loop_step,
              cmd.div_start, cmd.dev_calc, cmd.square, cmd.dev_store, cmd.filter,
              cmd.res_load}))
    else $error("more than one datapath command in a cycle");

  // Samples are processed one at a time: an accepted sample closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a sample is in flight");

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten while stalled");

  // Only a valid status carries a nonzero level.
  a_zero_level: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != rmvd_pkg::STAT_VALID)) |-> (out_ch.level == '0))
    else $error("nonzero level with a non-valid status");

endmodule
